// ----- rtl/core/urb_pkg.sv -----
// Shared types, address map constants and helpers for the UART register block.
package urb_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2
  } kind_t;

  localparam logic [3:0] SLOT_MODE   = 4'h0;
  localparam logic [3:0] SLOT_STATUS = 4'h1;
  localparam logic [3:0] SLOT_TX     = 4'h2;
  localparam logic [3:0] SLOT_RX     = 4'h3;
  localparam logic [3:0] SLOT_BAUD   = 4'h4;

  localparam logic [3:0] SUB_WRITE = 4'h0;
  localparam logic [3:0] SUB_CLR   = 4'h4;
  localparam logic [3:0] SUB_SET   = 4'h8;
  localparam logic [3:0] SUB_INV   = 4'hC;

  localparam int ST_URXDA = 0;
  localparam int ST_OERR  = 1;
  localparam int ST_TRMT  = 8;
  localparam int ST_UTXBF = 9;
  localparam int ST_UTXEN = 10;
  localparam int ST_URXEN = 12;
  localparam int MD_ON    = 15;

  localparam int REQ_DATA_W = 48;
  localparam int RSP_DATA_W = 48;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  address;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_receive;
    logic        irq_transmit;
    logic        irq_error;
  } rsp_t;

  function automatic logic [31:0] apply_sub(input logic [31:0] cur, input logic [31:0] v,
                                            input logic [3:0] sub);
    logic [31:0] r;
    r = cur;
    case (sub)
      SUB_WRITE: r = v;
      SUB_CLR:   r = cur & ~v;
      SUB_SET:   r = cur | v;
      SUB_INV:   r = cur ^ v;
      default:   r = cur;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] refresh_status(input logic [31:0] st, input logic full);
    logic [31:0] r;
    r = st;
    r[ST_TRMT]  = 1'b1;
    r[ST_UTXBF] = 1'b0;
    r[ST_URXDA] = full;
    return r;
  endfunction

endpackage

// ----- rtl/core/urb_in_reg.sv -----
// Input register stage for incoming requests.
module urb_in_reg
  import urb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            s_tuser,
  input  logic [REQ_DATA_W-1:0] s_tdata,
  input  logic                  advance,
  output logic                  req_valid,
  output req_t                  req
);

  assign s_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req.kind       <= kind_t'(s_tuser);
      req.address    <= s_tdata[7:0];
      req.write_data <= s_tdata[39:8];
      req.rx_byte    <= s_tdata[47:40];
    end
  end

endmodule

// ----- rtl/core/urb_regfile.sv -----
// Register file with set/clear/invert decode, receive buffer and interrupt levels.
module urb_regfile
  import urb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  req_t req,
  output rsp_t rsp
);

  logic [31:0] mode_reg, mode_reg_next;
  logic [31:0] status_reg, status_reg_next;
  logic [31:0] baud_reg, baud_reg_next;
  logic [7:0]  rx_data, rx_data_next;
  logic        rx_full, rx_full_next;
  logic        err_level, err_level_next;
  logic [3:0]  slot;
  logic [3:0]  sub;

  assign slot = req.address[7:4];
  assign sub  = req.address[3:0];

  always_comb begin
    mode_reg_next   = mode_reg;
    status_reg_next = status_reg;
    baud_reg_next   = baud_reg;
    rx_data_next    = rx_data;
    rx_full_next    = rx_full;
    err_level_next  = err_level;
    rsp.read_data   = '0;
    rsp.tx_valid    = 1'b0;
    rsp.tx_byte     = '0;
    case (req.kind)
      KIND_READ: begin
        status_reg_next = refresh_status(status_reg, rx_full);
        case (slot)
          SLOT_RX: begin
            if (rx_full) begin
              rsp.read_data   = {24'd0, rx_data};
              rx_full_next    = 1'b0;
              status_reg_next = refresh_status(status_reg_next, 1'b0);
            end
          end
          SLOT_MODE:   rsp.read_data = mode_reg;
          SLOT_STATUS: rsp.read_data = status_reg_next;
          SLOT_BAUD:   rsp.read_data = baud_reg;
          default:     rsp.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        case (slot)
          SLOT_TX: begin
            rsp.tx_valid = 1'b1;
            rsp.tx_byte  = req.write_data[7:0];
          end
          SLOT_MODE: mode_reg_next = apply_sub(mode_reg, req.write_data, sub);
          SLOT_STATUS: begin
            status_reg_next = apply_sub(status_reg, req.write_data, sub);
            if (!status_reg_next[ST_OERR]) begin
              err_level_next = 1'b0;
            end
          end
          SLOT_BAUD: baud_reg_next = apply_sub(baud_reg, req.write_data, sub);
          default: ;
        endcase
      end
      KIND_RX: begin
        if (rx_full) begin
          status_reg_next[ST_OERR] = 1'b1;
          err_level_next           = 1'b1;
        end else begin
          rx_data_next    = req.rx_byte;
          rx_full_next    = 1'b1;
          status_reg_next = refresh_status(status_reg, 1'b1);
        end
      end
      default: ;
    endcase
    rsp.irq_receive  = rx_full_next && status_reg_next[ST_URXEN];
    rsp.irq_transmit = mode_reg_next[MD_ON] && status_reg_next[ST_UTXEN];
    rsp.irq_error    = err_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= '0;
      status_reg <= 32'd1 << ST_TRMT;
      baud_reg   <= '0;
      rx_data    <= '0;
      rx_full    <= 1'b0;
      err_level  <= 1'b0;
    end else if (advance) begin
      mode_reg   <= mode_reg_next;
      status_reg <= status_reg_next;
      baud_reg   <= baud_reg_next;
      rx_data    <= rx_data_next;
      rx_full    <= rx_full_next;
      err_level  <= err_level_next;
    end
  end

endmodule

// ----- rtl/core/urb_out_reg.sv -----
// Result register feeding the master-side stream.
module urb_out_reg
  import urb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  rsp_t                  rsp,
  output logic                  out_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [RSP_DATA_W-1:0] m_tdata
);

  rsp_t rsp_q;

  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  assign m_tdata = {4'd0, rsp_q.irq_error, rsp_q.irq_transmit, rsp_q.irq_receive,
                    rsp_q.tx_byte, rsp_q.tx_valid, rsp_q.read_data};

endmodule

// ----- rtl/core/uart_register_block.sv -----
// Top level of the UART register block.
//
// Requests enter on the s_* stream: s_tuser is the kind (read, write, received
// byte), s_tdata carries address, write data and received byte. Each request
// yields exactly one response on the m_* stream with read data, transmit byte
// and the three interrupt levels after the request.
// A response is valid once its request has passed both registers: the input
// register takes the request at the accepting edge, and the register file
// update and the result register load complete together when it advances.
// Throughput is one request per cycle while m_tready is not held off; the
// register update is a single decode and modify step between the two registers.
// Reset clears MODE, BAUD, the receive buffer and the error level, and leaves
// STATUS with only TRMT set. Both streams come up empty.
// When the receiver holds off m_tready, the result register holds its
// response, the input register keeps one more request, and s_tready then
// drops until the response is taken. No request is lost or reordered.
module uart_register_block
  import urb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            s_tuser,  // kind
  input  logic [REQ_DATA_W-1:0] s_tdata,  // address[7:0], write_data[39:8], rx_byte[47:40]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // read_data[31:0], tx_valid[32], tx_byte[40:33], irq_receive[41],
  // irq_transmit[42], irq_error[43], zero pad[47:44]
  output logic [RSP_DATA_W-1:0] m_tdata
);

  logic req_valid;
  req_t req;
  rsp_t rsp;
  logic out_ready;
  logic advance;

  assign advance = req_valid && out_ready;

  urb_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .req_valid(req_valid),
    .req      (req)
  );

  urb_regfile u_regs (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .req    (req),
    .rsp    (rsp)
  );

  urb_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .rsp      (rsp),
    .out_ready(out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/core/urb_checker.sv -----
// Port-level checker for the UART register block, bound to the top level.
module urb_checker
  import urb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [RSP_DATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("response valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled response changed");

  a_tx_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[40:33] == 8'd0)
    else $error("tx byte without tx valid");

  a_tx_no_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0 && m_tdata[47:44] == 4'd0)
    else $error("transmit response carries read data");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("request side stalled without output stall");

endmodule

bind uart_register_block urb_checker u_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
